@@ design/azimuth_sector_blanking_macros.svh @@
`ifndef AZIMUTH_SECTOR_BLANKING_MACROS_SVH
`define AZIMUTH_SECTOR_BLANKING_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ASB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ASB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/asb_pkg.sv @@
package asb_pkg;

	localparam int CFG_W = 20;
	localparam logic [CFG_W-1:0] REFRESH_RESET = 20'd1000;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_LOAD,
		KIND_CLEAR
	} kind_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [15:0]        azimuth;
		logic signed [15:0] elevation;
		logic [31:0]        sample_time;
		logic [15:0]        sector_start;
		logic [15:0]        sector_end;
		logic signed [15:0] lower_limit;
		logic signed [15:0] upper_limit;
	} in_t;

	typedef struct packed {
		logic               blank_on;
		logic               changing;
		logic [15:0]        command_azimuth;
		logic signed [15:0] command_elevation;
		logic [31:0]        command_time;
	} out_t;

	typedef struct packed {
		kind_t              kind;
		logic [15:0]        azimuth;
		logic signed [15:0] elevation;
		logic [31:0]        sample_time;
		logic [15:0]        sector_start;
		logic [15:0]        span;
		logic               wrap;
		logic signed [15:0] lower_limit;
		logic signed [15:0] upper_limit;
	} job_t;

	typedef struct packed {
		logic               marked;
		logic signed [15:0] lower;
		logic signed [15:0] upper;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

@@ design/asb_front.sv @@
module asb_front (
	input  logic               start,
	output logic               busy,
	input  asb_pkg::in_t       item,
	input  asb_pkg::queue_stat_t q_stat,
	input  logic               init_busy,
	output logic               push,
	output asb_pkg::job_t      push_job
);
	import asb_pkg::*;

	logic accept;
	logic known;

	assign busy   = q_stat.full || init_busy;
	assign accept = start && !busy;

	always_comb begin
		known         = 1'b1;
		push_job.kind = KIND_SAMPLE;
		unique case (item.operation)
			OP_SAMPLE: push_job.kind = KIND_SAMPLE;
			OP_LOAD:   push_job.kind = KIND_LOAD;
			OP_CLEAR:  push_job.kind = KIND_CLEAR;
			default:   known = 1'b0;
		endcase
		push_job.azimuth      = item.azimuth;
		push_job.elevation    = item.elevation;
		push_job.sample_time  = item.sample_time;
		push_job.sector_start = item.sector_start;
		push_job.span         = item.sector_end - item.sector_start;
		push_job.wrap         = item.sector_start > item.sector_end;
		push_job.lower_limit  = item.lower_limit;
		push_job.upper_limit  = item.upper_limit;
	end

	// unused op code is taken and dropped
	assign push = accept && known;

endmodule

@@ design/asb_queue.sv @@
module asb_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  asb_pkg::job_t        push_job,
	input  logic                 pop,
	output asb_pkg::job_t        pop_job,
	output asb_pkg::queue_stat_t stat
);
	import asb_pkg::*;

	job_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign pop_job    = ent_q[rd_ptr_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ design/asb_back.sv @@
module asb_back #(
	parameter int LUT_BITS = 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  asb_pkg::queue_stat_t       q_stat,
	input  asb_pkg::job_t              job,
	output logic                       pop,
	input  logic [asb_pkg::CFG_W-1:0]  refresh_interval,
	output logic                       init_busy,
	output logic                       result_valid,
	output asb_pkg::out_t              result
);
	import asb_pkg::*;

	localparam int AW    = LUT_BITS;
	localparam int NBINS = 1 << LUT_BITS;
	localparam int SHIFT = 16 - LUT_BITS;
	localparam int HALF  = 1 << (SHIFT - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECIDE,
		ST_LOAD,
		ST_CLEAR
	} state_t;

	state_t             state_q;
	entry_t             mem_q [NBINS];
	entry_t             rd_q;
	logic [AW:0]        pos_q;
	logic [AW:0]        remain_q;
	logic               wrap_q;
	logic signed [15:0] lo_q;
	logic signed [15:0] hi_q;
	logic [15:0]        az_q;
	logic signed [15:0] el_q;
	logic [31:0]        time_q;
	logic               due_q;
	logic               blank_q;
	logic [31:0]        last_time_q;
	logic               first_q;
	logic               result_valid_q;
	out_t               result_q;

	logic [16:0]   bin_sum;
	logic [16:0]   base_sum;
	logic [AW:0]   bin_full;
	logic [AW:0]   base_full;
	logic [AW:0]   count_full;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          we;
	entry_t        wdata;
	logic [31:0]   elapsed;
	logic          due;
	logic          blanked;
	logic          emit;

	// round to nearest bin, clamp to the last one
	assign bin_sum    = {1'b0, job.azimuth} + 17'(HALF);
	assign bin_full   = bin_sum[16:SHIFT];
	assign raddr      = bin_full[AW] ? {AW{1'b1}} : bin_full[AW-1:0];
	assign base_sum   = {1'b0, job.sector_start} + 17'(HALF);
	assign base_full  = base_sum[16:SHIFT];
	assign count_full = {1'b0, job.span[15:SHIFT]} + (AW+1)'(1);

	assign elapsed = job.sample_time - last_time_q;
	assign due     = first_q || (elapsed >= {12'd0, refresh_interval});

	assign blanked = rd_q.marked && (el_q >= rd_q.lower) && (el_q <= rd_q.upper);
	assign emit    = due_q || (blanked != blank_q);

	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign init_busy = state_q == ST_INIT;

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[AW-1:0];
		wdata = '0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				we = 1'b1;
			end
			ST_LOAD: begin
				we           = 1'b1;
				// wrapped sector folds back past zero, a plain one clamps
				waddr        = (!wrap_q && pos_q[AW]) ? {AW{1'b1}} : pos_q[AW-1:0];
				wdata.marked = 1'b1;
				wdata.lower  = lo_q;
				wdata.upper  = hi_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			pos_q          <= '0;
			blank_q        <= 1'b0;
			last_time_q    <= 32'd0;
			first_q        <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_INIT, ST_CLEAR: begin
					pos_q <= pos_q + (AW+1)'(1);
					if (pos_q[AW-1:0] == {AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!q_stat.empty) begin
						unique case (job.kind)
							KIND_SAMPLE: begin
								az_q    <= job.azimuth;
								el_q    <= job.elevation;
								time_q  <= job.sample_time;
								due_q   <= due;
								state_q <= ST_DECIDE;
							end
							KIND_LOAD: begin
								pos_q    <= base_full;
								remain_q <= count_full;
								wrap_q   <= job.wrap;
								lo_q     <= job.lower_limit;
								hi_q     <= job.upper_limit;
								state_q  <= ST_LOAD;
							end
							KIND_CLEAR: begin
								pos_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_LOAD: begin
					pos_q    <= pos_q + (AW+1)'(1);
					remain_q <= remain_q - (AW+1)'(1);
					if (remain_q == (AW+1)'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DECIDE: begin
					if (emit) begin
						result_valid_q             <= 1'b1;
						result_q.blank_on          <= blanked;
						result_q.changing          <= !due_q;
						result_q.command_azimuth   <= az_q;
						result_q.command_elevation <= el_q;
						result_q.command_time      <= time_q;
						blank_q                    <= blanked;
						last_time_q                <= time_q;
						first_q                    <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ design/azimuth_sector_blanking.sv @@
// Azimuth sector blanking: per angle sample, looks up a 2^LUT_BITS bin table and
// emits a blanking command on a state change, on the first sample, or when the
// refresh interval has run out. Results cannot be stalled: result_valid is high
// for one cycle per command and the receiver must take it then. Items queue two
// deep behind start/busy. In the back end an angle sample takes a table read and
// then a decision, a sector load does one table write per bin of the sector, and
// a clear writes zero to every bin. After reset busy stays high while the table is
// swept to zero; configuration writes are taken at any time.
`include "azimuth_sector_blanking_macros.svh"

module azimuth_sector_blanking #(
	parameter int LUT_BITS = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  asb_pkg::in_t              item,
	input  logic                      cfg_we,
	input  logic [asb_pkg::CFG_W-1:0] cfg_wdata,
	output logic                      result_valid,
	output asb_pkg::out_t             result
);
	import asb_pkg::*;

	logic [CFG_W-1:0] refresh_q;
	queue_stat_t      q_stat;
	logic             init_busy;
	logic             push;
	job_t             push_job;
	logic             pop;
	job_t             pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= REFRESH_RESET;
		end else if (cfg_we) begin
			refresh_q <= cfg_wdata;
		end
	end

	asb_front u_front (
		.start     (start),
		.busy      (busy),
		.item      (item),
		.q_stat    (q_stat),
		.init_busy (init_busy),
		.push      (push),
		.push_job  (push_job)
	);

	asb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (q_stat)
	);

	asb_back #(
		.LUT_BITS (LUT_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_stat           (q_stat),
		.job              (pop_job),
		.pop              (pop),
		.refresh_interval (refresh_q),
		.init_busy        (init_busy),
		.result_valid     (result_valid),
		.result           (result)
	);

	`ASB_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "back-to-back result strobes")
	`ASB_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "item pushed into full queue")
	`ASB_ASSERT_NOW(a_init_empty, init_busy, q_stat.empty && !push, "item queued during clear pass")

endmodule
